@@ src/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros for checker modules. Each macro expects signals
// named clk and arst_n in the scope where it is used.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset
`define BPC_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset
`define BPC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ src/bpc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpc_pkg
// Types and constants shared by the button press classifier modules.
// ----------------------------------------------------------------------------
package bpc_pkg;

	// Field widths
	localparam int MASK_W = 8;
	localparam int TIME_W = 32;
	localparam int THR_W  = 16;
	localparam int IN_W   = 40;
	localparam int OUT_W  = 16;

	// Default button count
	localparam int NUM_BUTTONS_DEF = 8;

	// Threshold reset values
	localparam logic [THR_W-1:0] LONG_PRESS_RST = 16'd1000;
	localparam logic [THR_W-1:0] MIN_PRESS_RST  = 16'd50;

	// Configuration register indexes
	localparam int CFG_ADDR_W = 1;
	localparam logic [CFG_ADDR_W-1:0] REG_LONG_PRESS = 1'b0;
	localparam logic [CFG_ADDR_W-1:0] REG_MIN_PRESS  = 1'b1;

	// Threshold set handed to the classifier
	typedef struct packed {
		logic [THR_W-1:0] long_ms;
		logic [THR_W-1:0] min_ms;
	} thr_t;

	// One result item, long_mask in the upper byte
	typedef struct packed {
		logic [MASK_W-1:0] long_mask;
		logic [MASK_W-1:0] short_mask;
	} result_t;

endpackage

@@ src/bpc_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpc_front
// Per-button press tracking: one lane per button compares elapsed time
// against both thresholds and updates its flags on every accepted scan.
// ----------------------------------------------------------------------------
module bpc_front #(
	parameter int NUM_BUTTONS = bpc_pkg::NUM_BUTTONS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        scan_fire,
	input  logic [bpc_pkg::MASK_W-1:0]  pressed_mask,
	input  logic [bpc_pkg::TIME_W-1:0]  now_ms,
	input  bpc_pkg::thr_t               thr,
	output bpc_pkg::result_t            res
);

	localparam int ZEXT_W = bpc_pkg::TIME_W - bpc_pkg::THR_W;

	logic [bpc_pkg::TIME_W-1:0] long_ext;
	logic [bpc_pkg::TIME_W-1:0] min_ext;
	logic [bpc_pkg::MASK_W-1:0] short_bits;
	logic [bpc_pkg::MASK_W-1:0] long_bits;

	assign long_ext = {{ZEXT_W{1'b0}}, thr.long_ms};
	assign min_ext  = {{ZEXT_W{1'b0}}, thr.min_ms};

	genvar b;
	generate
		for (b = 0; b < NUM_BUTTONS; b++) begin : g_lane
			logic                       held_q;
			logic                       long_rep_q;
			logic [bpc_pkg::TIME_W-1:0] start_q;
			logic [bpc_pkg::TIME_W-1:0] elapsed;
			logic                       down;
			logic                       long_hit;
			logic                       short_hit;

			// Buttons past the mask width are never pressed
			if (b < bpc_pkg::MASK_W) begin : g_bit
				assign down          = pressed_mask[b];
				assign short_bits[b] = short_hit;
				assign long_bits[b]  = long_hit;
			end else begin : g_nobit
				assign down = 1'b0;
			end

			// Classify this button against the thresholds
			assign elapsed   = now_ms - start_q;
			assign long_hit  = down & held_q & ~long_rep_q & (elapsed >= long_ext);
			assign short_hit = ~down & held_q & (elapsed > min_ext) & (elapsed < long_ext);

			// Track held and long-reported flags
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					held_q     <= 1'b0;
					long_rep_q <= 1'b0;
				end else if (scan_fire) begin
					if (down) begin
						held_q <= 1'b1;
						if (long_hit) begin
							long_rep_q <= 1'b1;
						end
					end else begin
						held_q     <= 1'b0;
						long_rep_q <= 1'b0;
					end
				end
			end

			// Capture press start on the first pressed scan
			always_ff @(posedge clk) begin
				if (scan_fire && down && !held_q) begin
					start_q <= now_ms;
				end
			end
		end

		// Tie off mask bits that have no button
		for (b = NUM_BUTTONS; b < bpc_pkg::MASK_W; b++) begin : g_unused
			assign short_bits[b] = 1'b0;
			assign long_bits[b]  = 1'b0;
		end
	endgenerate

	assign res.short_mask = short_bits;
	assign res.long_mask  = long_bits;

endmodule

@@ src/bpc_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpc_queue
// Two-entry result queue that drives the output channel from registers.
// ----------------------------------------------------------------------------
module bpc_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  bpc_pkg::result_t  push_data,
	output logic              full,
	output logic              pop_valid,
	input  logic              pop_ready,
	output bpc_pkg::result_t  pop_data
);

	bpc_pkg::result_t mem_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;
	logic             pop;

	assign full      = (count_q == 2'd2);
	assign pop_valid = (count_q != 2'd0);
	assign pop       = pop_valid & pop_ready;
	assign pop_data  = mem_q[rd_ptr_q];

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	// Store pushed item
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

@@ src/button_short_long_press_classifier.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_short_long_press_classifier
// Classifies button scans into short-press and long-press event masks.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel takes one scan per item: pressed_mask and now_ms.
//   m_* channel gives one item per scan: short_mask and long_mask.
//   cfg_we/cfg_addr/cfg_wdata write long_press_ms (index 0) and
//   min_press_ms (index 1); write only while the block is idle.
// Result: an accepted scan's result is registered in the queue, behind earlier results.
// Throughput: one scan per cycle while the result queue is not full; each button
//   lane does one 32-bit subtract and compare per scan, and the two-entry result
//   queue lets a new scan enter while an earlier result still waits.
// Reset: all buttons read as released, no press pending, thresholds return
//   to 1000 ms and 50 ms, the result queue empties.
// Stall: while m_tready is low results collect in the queue; once it holds
//   two items s_tready drops and scans wait upstream.
// ----------------------------------------------------------------------------
module button_short_long_press_classifier #(
	parameter int NUM_BUTTONS = bpc_pkg::NUM_BUTTONS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// Scan input
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [bpc_pkg::IN_W-1:0]       s_tdata,   // [7:0] pressed_mask, [39:8] now_ms
	// Event output
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [bpc_pkg::OUT_W-1:0]      m_tdata,   // [7:0] short_mask, [15:8] long_mask
	// Configuration writes
	input  logic                           cfg_we,
	input  logic [bpc_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input  logic [bpc_pkg::THR_W-1:0]      cfg_wdata
);

	bpc_pkg::thr_t    thr_q;
	bpc_pkg::result_t res;
	bpc_pkg::result_t out_res;
	logic             scan_fire;
	logic             queue_full;

	assign s_tready  = ~queue_full;
	assign scan_fire = s_tvalid & s_tready;

	// Hold threshold registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q.long_ms <= bpc_pkg::LONG_PRESS_RST;
			thr_q.min_ms  <= bpc_pkg::MIN_PRESS_RST;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				bpc_pkg::REG_LONG_PRESS: thr_q.long_ms <= cfg_wdata;
				bpc_pkg::REG_MIN_PRESS:  thr_q.min_ms  <= cfg_wdata;
				default:                 thr_q         <= thr_q;
			endcase
		end
	end

	bpc_front #(
		.NUM_BUTTONS (NUM_BUTTONS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.scan_fire    (scan_fire),
		.pressed_mask (s_tdata[bpc_pkg::MASK_W-1:0]),
		.now_ms       (s_tdata[bpc_pkg::MASK_W +: bpc_pkg::TIME_W]),
		.thr          (thr_q),
		.res          (res)
	);

	bpc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (scan_fire),
		.push_data (res),
		.full      (queue_full),
		.pop_valid (m_tvalid),
		.pop_ready (m_tready),
		.pop_data  (out_res)
	);

	assign m_tdata = {out_res.long_mask, out_res.short_mask};

endmodule

@@ src/bpc_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpc_checker
// Port-level checks on the press classifier, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bpc_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tvalid,
	input logic                           s_tready,
	input logic [bpc_pkg::IN_W-1:0]       s_tdata,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [bpc_pkg::OUT_W-1:0]      m_tdata
);

	// Keep a stalled result on the channel
	`BPC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")

	// A button never completes a short and a long press in the same scan
	`BPC_ASSERT_IMPL(a_disjoint, m_tvalid, (m_tdata[7:0] & m_tdata[15:8]) == 8'd0,
		"short and long press on one button")

	// A scan into an empty block shows its result next cycle
	`BPC_ASSERT_NEXT(a_latency, s_tvalid && s_tready && !m_tvalid, m_tvalid,
		"missing result one cycle after scan")

	// Short presses only on released buttons, long presses only on held ones
	`BPC_ASSERT_NEXT(a_mask_match, s_tvalid && s_tready && !m_tvalid,
		((m_tdata[7:0] & $past(s_tdata[7:0])) == 8'd0) &&
		((m_tdata[15:8] & ~$past(s_tdata[7:0])) == 8'd0),
		"event on a button in the wrong state")

endmodule

bind button_short_long_press_classifier bpc_checker u_bpc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

@@ tb/press_event_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// press_event_checker
// Watches the scan, event and threshold-write ports of the press classifier.
// Keeps its own per-button hold state, predicts the event item of every
// accepted scan, and compares each delivered event item in order.
// ----------------------------------------------------------------------------
module press_event_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	input  logic                           s_tready,
	input  logic [bpc_pkg::IN_W-1:0]       s_tdata,   // [7:0] pressed_mask, [39:8] now_ms
	input  logic                           m_tvalid,
	input  logic                           m_tready,
	input  logic [bpc_pkg::OUT_W-1:0]      m_tdata,   // [7:0] short_mask, [15:8] long_mask
	input  logic                           cfg_we,
	input  logic [bpc_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input  logic [bpc_pkg::THR_W-1:0]      cfg_wdata,
	output int                             mismatches,
	output int                             events_pending
);
	import bpc_pkg::*;

	localparam int NB = NUM_BUTTONS_DEF;

	// Per-button hold state and the live thresholds
	logic [NB-1:0]     held;
	logic [NB-1:0]     long_done;
	logic [TIME_W-1:0] press_t [NB];
	logic [THR_W-1:0]  long_thr;
	logic [THR_W-1:0]  min_thr;

	// Event items owed by the block, oldest first
	result_t expected_events [$];
	result_t got_ev;
	result_t want_ev;
	result_t scan_ev;

	task automatic report_mismatch(input string what, input logic [7:0] want,
		input logic [7:0] got);
		$display("ERROR at %0t ns: %s: expected %02h, got %02h", $time, what, want, got);
		mismatches++;
	endtask

	// Classify one scan and advance the hold state
	task automatic classify_scan(input logic [MASK_W-1:0] mask,
		input logic [TIME_W-1:0] now, output result_t ev);
		logic [TIME_W-1:0] held_for;
		logic [TIME_W-1:0] long_w;
		logic [TIME_W-1:0] min_w;
		ev = '0;
		long_w = {{(TIME_W-THR_W){1'b0}}, long_thr};
		min_w = {{(TIME_W-THR_W){1'b0}}, min_thr};
		for (int b = 0; b < NB; b++) begin
			held_for = now - press_t[b];
			if (mask[b]) begin
				if (!held[b]) begin
					// first pressed scan only records the time
					press_t[b] = now;
					held[b] = 1'b1;
				end else if (held_for >= long_w && !long_done[b]) begin
					long_done[b] = 1'b1;
					ev.long_mask[b] = 1'b1;
				end
			end else begin
				if (held[b] && held_for > min_w && held_for < long_w)
					ev.short_mask[b] = 1'b1;
				held[b] = 1'b0;
				long_done[b] = 1'b0;
			end
		end
	endtask

	// Compare delivered items, track writes, predict accepted scans
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held = '0;
			long_done = '0;
			for (int b = 0; b < NB; b++)
				press_t[b] = '0;
			long_thr = LONG_PRESS_RST;
			min_thr = MIN_PRESS_RST;
			expected_events.delete();
			mismatches = 0;
			events_pending = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got_ev = m_tdata;
				if (expected_events.size() == 0) begin
					report_mismatch("event item with no scan pending", 8'h00,
						got_ev.short_mask);
				end else begin
					want_ev = expected_events.pop_front();
					if (got_ev.short_mask !== want_ev.short_mask)
						report_mismatch("short_mask", want_ev.short_mask, got_ev.short_mask);
					if (got_ev.long_mask !== want_ev.long_mask)
						report_mismatch("long_mask", want_ev.long_mask, got_ev.long_mask);
				end
			end
			if (cfg_we) begin
				case (cfg_addr)
					REG_LONG_PRESS: long_thr = cfg_wdata;
					REG_MIN_PRESS:  min_thr = cfg_wdata;
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				classify_scan(s_tdata[MASK_W-1:0], s_tdata[MASK_W +: TIME_W], scan_ev);
				expected_events.push_back(scan_ev);
			end
			events_pending = expected_events.size();
		end
	end

endmodule

@@ tb/button_short_long_press_classifier_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_short_long_press_classifier_tb
// Drives button scans into the press classifier: a directed set around the
// press thresholds and time wrap, then random press/hold/release traffic
// under several threshold settings, with bursty input and a stalling output.
// ----------------------------------------------------------------------------
module button_short_long_press_classifier_tb;
	import bpc_pkg::*;

	typedef enum int {RX_OPEN, RX_MOSTLY, RX_SPARSE, RX_PERIODIC} rx_mode_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_W-1:0]       s_tdata = '0;    // [7:0] pressed_mask, [39:8] now_ms
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_W-1:0]      m_tdata;         // [7:0] short_mask, [15:8] long_mask
	logic                  cfg_we = 1'b0;
	logic [CFG_ADDR_W-1:0] cfg_addr = REG_LONG_PRESS;
	logic [THR_W-1:0]      cfg_wdata = '0;
	int                    mismatches;
	int                    events_pending;

	// Scan generator state
	logic [MASK_W-1:0] mask_now = '0;
	logic [TIME_W-1:0] clock_ms = '0;
	logic [TIME_W-1:0] down_at [MASK_W];
	logic [THR_W-1:0]  cur_long = LONG_PRESS_RST;
	logic [THR_W-1:0]  cur_min = MIN_PRESS_RST;
	int                burst_left = 0;
	bit                hold_req = 1'b0;

	// Receiver state
	rx_mode_t rx_mode = RX_OPEN;
	int       rx_left = 0;
	int       rx_hold = 0;
	int       rx_tick = 0;

	// Threshold settings per phase
	logic [THR_W-1:0] long_set [7] = '{16'd0, 16'hFFFF, 16'd100, 16'd200, 16'hFFFF, 16'd0, 16'd30};
	logic [THR_W-1:0] min_set  [7] = '{16'd0, 16'hFFFF, 16'd100, 16'd10, 16'd0, 16'hFFFF, 16'd5};

	button_short_long_press_classifier DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata)
	);

	press_event_checker u_chk (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.cfg_we         (cfg_we),
		.cfg_addr       (cfg_addr),
		.cfg_wdata      (cfg_wdata),
		.mismatches     (mismatches),
		.events_pending (events_pending)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Offer one scan item at a falling edge, return at the falling edge after acceptance
	task automatic send_scan(input logic [MASK_W-1:0] mask, input logic [TIME_W-1:0] now);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 2) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 3);
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		s_tdata = {now, mask};
		s_tvalid = 1'b1;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		@(negedge clk);
		// remember press starts for threshold-edge targeting
		for (int b = 0; b < MASK_W; b++)
			if (mask[b] && !mask_now[b])
				down_at[b] = now;
		mask_now = mask;
		clock_ms = now;
	endtask

	// Drain all owed event items before touching the thresholds
	task automatic write_thresholds(input logic [THR_W-1:0] long_ms,
		input logic [THR_W-1:0] min_ms);
		s_tvalid = 1'b0;
		while (events_pending != 0)
			@(negedge clk);
		repeat (3) @(negedge clk);
		cfg_we = 1'b1;
		cfg_addr = REG_LONG_PRESS;
		cfg_wdata = long_ms;
		@(negedge clk);
		cfg_addr = REG_MIN_PRESS;
		cfg_wdata = min_ms;
		@(negedge clk);
		cfg_we = 1'b0;
		cur_long = long_ms;
		cur_min = min_ms;
	endtask

	// Random press/hold/release traffic with some threshold-edge hits and noise
	task automatic random_scans(input int n, input bit squeeze);
		int                pick;
		int                b;
		logic [MASK_W-1:0] flip;
		logic [TIME_W-1:0] spread;
		logic [TIME_W-1:0] offs;
		for (int i = 0; i < n; i++) begin
			if (squeeze && i == n / 3) begin
				// long output hold-off while input keeps coming
				hold_req = 1'b1;
				burst_left = 48;
			end
			pick = $urandom_range(0, 99);
			if (pick < 8) begin
				send_scan(MASK_W'($urandom), $urandom);
			end else if (pick < 30 && mask_now != '0) begin
				// land one held button right on a threshold
				b = $urandom_range(0, MASK_W - 1);
				while (!mask_now[b])
					b = $urandom_range(0, MASK_W - 1);
				case ($urandom_range(0, 5))
					0: offs = {{(TIME_W-THR_W){1'b0}}, cur_min};
					1: offs = cur_min + 32'd1;
					2: offs = cur_long - 32'd1;
					3: offs = {{(TIME_W-THR_W){1'b0}}, cur_long};
					4: offs = cur_long + 32'd1;
					default: offs = '0;
				endcase
				flip = '0;
				flip[b] = 1'($urandom_range(0, 1));
				send_scan(mask_now ^ flip, down_at[b] + offs);
			end else begin
				spread = ((cur_long > cur_min) ? cur_long : cur_min) + 32'd8;
				flip = '0;
				for (int k = 0; k < MASK_W; k++)
					if ($urandom_range(0, 4) == 0)
						flip[k] = 1'b1;
				send_scan(mask_now ^ flip, clock_ms + $urandom_range(0, spread / 3));
			end
		end
	endtask

	// Output side: rotating stall patterns plus requested long hold-offs
	initial begin
		forever begin
			@(negedge clk);
			if (rx_hold > 0) begin
				rx_hold--;
				m_tready = 1'b0;
			end else if (hold_req) begin
				hold_req = 1'b0;
				rx_hold = 60;
				m_tready = 1'b0;
			end else begin
				if (rx_left == 0) begin
					rx_mode = rx_mode_t'($urandom_range(0, 3));
					rx_left = $urandom_range(8, 80);
				end
				rx_left--;
				rx_tick++;
				case (rx_mode)
					RX_OPEN:   m_tready = 1'b1;
					RX_MOSTLY: m_tready = ($urandom_range(0, 9) < 7);
					RX_SPARSE: m_tready = ($urandom_range(0, 9) < 3);
					default:   m_tready = ((rx_tick % 5) >= 2);
				endcase
			end
		end
	end

	// Stimulus and verdict
	initial begin
		for (int b = 0; b < MASK_W; b++)
			down_at[b] = '0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset thresholds: all buttons across the time wrap
		send_scan(8'h00, 32'h0000_0000);
		send_scan(8'hFF, 32'hFFFF_FF00);
		send_scan(8'hFF, 32'hFFFF_FF64);
		send_scan(8'hF0, 32'hFFFF_FF64);
		send_scan(8'hF0, 32'hFFFF_FF00 + 32'd1000);
		send_scan(8'hF0, 32'hFFFF_FF00 + 32'd3000);
		send_scan(8'h00, 32'hFFFF_FF00 + 32'd3001);
		// release exactly at and just past the noise threshold
		send_scan(8'h02, 32'd1000);
		send_scan(8'h00, 32'd1050);
		send_scan(8'h02, 32'd2000);
		send_scan(8'h00, 32'd2051);
		// release just under the long threshold, then hold to it
		send_scan(8'h04, 32'd3000);
		send_scan(8'h04, 32'd3999);
		send_scan(8'h00, 32'd3999);
		send_scan(8'h04, 32'd5000);
		send_scan(8'h04, 32'd6000);
		send_scan(8'h00, 32'd6000);
		// release after a long press whose elapsed time drops back below
		send_scan(8'h80, 32'd10);
		send_scan(8'h80, 32'd1010);
		send_scan(8'h00, 32'd110);
		send_scan(8'hFF, 32'hFFFF_FFFF);
		send_scan(8'h00, 32'hFFFF_FFFF);
		send_scan(8'h55, 32'h0000_0000);
		send_scan(8'hAA, 32'h1234_5678);
		send_scan(8'h00, 32'hEDCB_A987);
		random_scans(60, 1'b1);

		// zero long threshold: first pressed scan still reports nothing
		write_thresholds(16'd0, 16'd0);
		send_scan(8'h01, clock_ms);
		send_scan(8'h01, clock_ms);
		send_scan(8'h00, clock_ms);
		random_scans(60, 1'b0);

		for (int p = 1; p < 7; p++) begin
			write_thresholds(long_set[p], min_set[p]);
			random_scans(60, p == 3);
		end
		write_thresholds(THR_W'($urandom_range(0, 2000)), THR_W'($urandom_range(0, 400)));
		random_scans(60, 1'b0);

		// drain
		s_tvalid = 1'b0;
		while (events_pending != 0)
			@(negedge clk);
		repeat (5) @(negedge clk);
		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// Run limit
	initial begin
		#5000000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
